@@ src/modbus_rtu_frame_receiver_macros.svh @@
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver assertion macros
// Concurrent assertion wrappers sampled on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_FRAME_RECEIVER_MACROS_SVH
`define MODBUS_RTU_FRAME_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF
`define MRFR_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("mrfr assertion failed");
`define MRFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrfr assertion failed");
`define MRFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrfr assertion failed");
`else
`define MRFR_ASSERT(lbl, expr)
`define MRFR_ASSERT_IMP(lbl, ante, cons)
`define MRFR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ src/mrfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrfr_pkg
// Shared types, constants and CRC helper for the Modbus RTU frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfr_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int LEN_W            = 9;

    localparam logic [7:0] ADDR_RESET      = 8'h01;
    localparam logic [7:0] FN_READ_HOLD    = 8'h03;
    localparam logic [7:0] FN_READ_INPUT   = 8'h04;
    localparam logic [7:0] FN_WRITE_COIL   = 8'h05;
    localparam logic [7:0] FN_WRITE_REG    = 8'h06;
    localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [LEN_W-1:0] BODY_FIXED = 9'd6;
    localparam logic [LEN_W-1:0] BODY_EXTRA = 9'd7;
    localparam logic [LEN_W-1:0] CRC_BYTES  = 9'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SYNC,
        S_SYNC_CHK0,
        S_SYNC_CHK1,
        S_LEN_RD1,
        S_LEN_CHK1,
        S_LEN_CHK6,
        S_LEN_EVAL,
        S_CRC_RD,
        S_CRC_STEP,
        S_CMP_RD0,
        S_CMP0,
        S_CMP_RD1,
        S_CMP1,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_ONE,
        RD_SIX,
        RD_IDX
    } t_rd_sel;

    typedef struct packed {
        logic    accept;
        logic    drop;
        logic    clear_count;
        t_rd_sel rd_sel;
        logic    idx_clr;
        logic    idx_inc;
        logic    crc_init;
        logic    crc_step;
        logic    fn16_load;
        logic    body_load;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_le2;
        logic count_ge2;
        logic count_lt8;
        logic count_lt_frame;
        logic frame_too_big;
        logic addr_ok;
        logic fn_ok;
        logic idx_done;
        logic crc_lo_ok;
        logic crc_hi_ok;
        logic out_taken;
        logic out_last;
    } t_status;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/mrfr_datapath.sv @@
// ----------------------------------------------------------------------------
// mrfr_datapath
// Circular byte store, length/CRC registers, address register, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_frame_receiver_macros.svh"

module mrfr_datapath #(
    parameter int BUFFER_BYTES = mrfr_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [7:0]       i_cfg_wr_data,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic             i_frame_stall,
    input  wire mrfr_pkg::t_cmd   i_cmd,
    output mrfr_pkg::t_status     o_status,
    output logic                  o_frame_valid,
    output logic [7:0]            o_frame_byte,
    output logic [5:0]            o_byte_index,
    output logic                  o_last_byte
);

    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = mrfr_pkg::LEN_W;

    function automatic logic [PW-1:0] f_wrap(input logic [PW:0] s);
        logic [PW:0] t;
        t = s;
        if (s >= (PW+1)'(BUFFER_BYTES)) begin
            t = s - (PW+1)'(BUFFER_BYTES);
        end
        return t[PW-1:0];
    endfunction

    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    r_rd_data;
    logic [PW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [PW-1:0] r_idx;
    logic          r_fn16;
    logic [LW-1:0] r_body;
    logic [15:0]   r_crc;
    logic [7:0]    r_addr;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [5:0]    r_out_idx;
    logic          r_out_last;

    logic [PW:0]   rd_off;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] head_inc;
    logic          full;
    logic [LW-1:0] frame;
    logic          taken;

    always_comb begin
        unique case (i_cmd.rd_sel)
            mrfr_pkg::RD_ZERO: rd_off = '0;
            mrfr_pkg::RD_ONE:  rd_off = (PW+1)'(1);
            mrfr_pkg::RD_SIX:  rd_off = (PW+1)'(6);
            mrfr_pkg::RD_IDX:  rd_off = {1'b0, r_idx};
            default:           rd_off = '0;
        endcase
    end

    assign rd_addr  = f_wrap({1'b0, r_head} + rd_off);
    assign wr_addr  = f_wrap({1'b0, r_head} + (PW+1)'(r_count));
    assign head_inc = (r_head == PW'(BUFFER_BYTES - 1)) ? '0 : r_head + 1'b1;
    assign full     = (r_count == CW'(BUFFER_BYTES));
    assign frame    = r_body + mrfr_pkg::CRC_BYTES;
    assign taken    = r_out_valid && !i_frame_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[wr_addr] <= i_rx_byte;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_addr      <= mrfr_pkg::ADDR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_addr <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                if (full) begin
                    r_head <= head_inc;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_cmd.drop) begin
                r_head  <= head_inc;
                r_count <= r_count - 1'b1;
            end else if (i_cmd.clear_count) begin
                r_count <= '0;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fn16_load) begin
            r_fn16 <= (r_rd_data == mrfr_pkg::FN_WRITE_MULTI);
        end
        if (i_cmd.body_load) begin
            r_body <= r_fn16 ? LW'(r_rd_data) + mrfr_pkg::BODY_EXTRA
                             : mrfr_pkg::BODY_FIXED;
        end
        if (i_cmd.crc_init) begin
            r_crc <= mrfr_pkg::CRC_INIT;
        end else if (i_cmd.crc_step) begin
            r_crc <= mrfr_pkg::crc_byte(r_crc, r_rd_data);
        end
        if (i_cmd.out_load) begin
            r_out_byte <= r_rd_data;
            r_out_idx  <= 6'(r_idx);
            r_out_last <= (LW'(r_idx) == r_body + LW'(1));
        end
    end

    always_comb begin
        o_status.count_zero     = (r_count == '0);
        o_status.count_le2      = (r_count <= CW'(2));
        o_status.count_ge2      = (r_count >= CW'(2));
        o_status.count_lt8      = (r_count < CW'(8));
        o_status.count_lt_frame = ((LW+1)'(r_count) < {1'b0, frame});
        o_status.frame_too_big  = ({1'b0, frame} > (LW+1)'(BUFFER_BYTES));
        o_status.addr_ok        = (r_rd_data == r_addr);
        o_status.fn_ok          = (r_rd_data == mrfr_pkg::FN_READ_HOLD)
                               || (r_rd_data == mrfr_pkg::FN_READ_INPUT)
                               || (r_rd_data == mrfr_pkg::FN_WRITE_COIL)
                               || (r_rd_data == mrfr_pkg::FN_WRITE_REG)
                               || (r_rd_data == mrfr_pkg::FN_WRITE_MULTI);
        o_status.idx_done       = (LW'(r_idx) == r_body);
        o_status.crc_lo_ok      = (r_rd_data == r_crc[7:0]);
        o_status.crc_hi_ok      = (r_rd_data == r_crc[15:8]);
        o_status.out_taken      = taken;
        o_status.out_last       = r_out_last;
    end

    assign o_frame_valid = r_out_valid;
    assign o_frame_byte  = r_out_byte;
    assign o_byte_index  = r_out_idx;
    assign o_last_byte   = r_out_last;

    `MRFR_ASSERT(a_count_bound, r_count <= CW'(BUFFER_BYTES))
    `MRFR_ASSERT_NXT(a_clear_empty, i_cmd.clear_count, r_count == '0)
    `MRFR_ASSERT_IMP(a_load_free, i_cmd.out_load, !r_out_valid)
    `MRFR_ASSERT_NXT(a_accept_grow, i_cmd.accept && !full, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

@@ src/mrfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrfr_ctrl
// Sequencer: store, resync, length check, CRC pass, compare and frame output.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rx_valid,
    input  wire mrfr_pkg::t_status i_status,
    output logic                   o_rx_stall,
    output mrfr_pkg::t_cmd         o_cmd
);

    mrfr_pkg::t_state r_state;
    mrfr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrfr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mrfr_pkg::S_IDLE: begin
                if (i_rx_valid) n_state = mrfr_pkg::S_CHECK;
            end
            mrfr_pkg::S_CHECK: begin
                if (i_status.count_le2) begin
                    n_state = mrfr_pkg::S_SYNC;
                end else if (i_status.count_lt8) begin
                    n_state = mrfr_pkg::S_IDLE;
                end else begin
                    n_state = mrfr_pkg::S_LEN_RD1;
                end
            end
            mrfr_pkg::S_SYNC: begin
                n_state = i_status.count_zero ? mrfr_pkg::S_IDLE : mrfr_pkg::S_SYNC_CHK0;
            end
            mrfr_pkg::S_SYNC_CHK0: begin
                if (!i_status.addr_ok) begin
                    n_state = mrfr_pkg::S_SYNC;
                end else if (i_status.count_ge2) begin
                    n_state = mrfr_pkg::S_SYNC_CHK1;
                end else begin
                    n_state = mrfr_pkg::S_IDLE;
                end
            end
            mrfr_pkg::S_SYNC_CHK1: begin
                n_state = i_status.fn_ok ? mrfr_pkg::S_IDLE : mrfr_pkg::S_SYNC;
            end
            mrfr_pkg::S_LEN_RD1:  n_state = mrfr_pkg::S_LEN_CHK1;
            mrfr_pkg::S_LEN_CHK1: n_state = mrfr_pkg::S_LEN_CHK6;
            mrfr_pkg::S_LEN_CHK6: n_state = mrfr_pkg::S_LEN_EVAL;
            mrfr_pkg::S_LEN_EVAL: begin
                if (i_status.frame_too_big) begin
                    n_state = mrfr_pkg::S_SYNC;
                end else if (i_status.count_lt_frame) begin
                    n_state = mrfr_pkg::S_IDLE;
                end else begin
                    n_state = mrfr_pkg::S_CRC_RD;
                end
            end
            mrfr_pkg::S_CRC_RD: begin
                n_state = i_status.idx_done ? mrfr_pkg::S_CMP_RD0 : mrfr_pkg::S_CRC_STEP;
            end
            mrfr_pkg::S_CRC_STEP: n_state = mrfr_pkg::S_CRC_RD;
            mrfr_pkg::S_CMP_RD0:  n_state = mrfr_pkg::S_CMP0;
            mrfr_pkg::S_CMP0: begin
                n_state = i_status.crc_lo_ok ? mrfr_pkg::S_CMP_RD1 : mrfr_pkg::S_SYNC;
            end
            mrfr_pkg::S_CMP_RD1:  n_state = mrfr_pkg::S_CMP1;
            mrfr_pkg::S_CMP1: begin
                n_state = i_status.crc_hi_ok ? mrfr_pkg::S_EMIT_RD : mrfr_pkg::S_SYNC;
            end
            mrfr_pkg::S_EMIT_RD:  n_state = mrfr_pkg::S_EMIT_LD;
            mrfr_pkg::S_EMIT_LD:  n_state = mrfr_pkg::S_EMIT_WAIT;
            mrfr_pkg::S_EMIT_WAIT: begin
                if (i_status.out_taken) begin
                    n_state = i_status.out_last ? mrfr_pkg::S_IDLE : mrfr_pkg::S_EMIT_RD;
                end
            end
            default: n_state = mrfr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = mrfr_pkg::RD_ZERO;
        o_rx_stall   = 1'b1;
        unique case (r_state)
            mrfr_pkg::S_IDLE: begin
                o_rx_stall   = 1'b0;
                o_cmd.accept = i_rx_valid;
            end
            mrfr_pkg::S_CHECK: ;
            mrfr_pkg::S_SYNC: o_cmd.rd_sel = mrfr_pkg::RD_ZERO;
            mrfr_pkg::S_SYNC_CHK0: begin
                o_cmd.drop   = !i_status.addr_ok;
                o_cmd.rd_sel = mrfr_pkg::RD_ONE;
            end
            mrfr_pkg::S_SYNC_CHK1: o_cmd.drop = !i_status.fn_ok;
            mrfr_pkg::S_LEN_RD1:   o_cmd.rd_sel = mrfr_pkg::RD_ONE;
            mrfr_pkg::S_LEN_CHK1: begin
                o_cmd.fn16_load = 1'b1;
                o_cmd.rd_sel    = mrfr_pkg::RD_SIX;
            end
            mrfr_pkg::S_LEN_CHK6: o_cmd.body_load = 1'b1;
            mrfr_pkg::S_LEN_EVAL: begin
                o_cmd.drop     = i_status.frame_too_big;
                o_cmd.crc_init = 1'b1;
                o_cmd.idx_clr  = 1'b1;
            end
            mrfr_pkg::S_CRC_RD: o_cmd.rd_sel = mrfr_pkg::RD_IDX;
            mrfr_pkg::S_CRC_STEP: begin
                o_cmd.crc_step = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            mrfr_pkg::S_CMP_RD0: o_cmd.rd_sel = mrfr_pkg::RD_IDX;
            mrfr_pkg::S_CMP0: begin
                o_cmd.drop    = !i_status.crc_lo_ok;
                o_cmd.idx_inc = i_status.crc_lo_ok;
            end
            mrfr_pkg::S_CMP_RD1: o_cmd.rd_sel = mrfr_pkg::RD_IDX;
            mrfr_pkg::S_CMP1: begin
                o_cmd.drop    = !i_status.crc_hi_ok;
                o_cmd.idx_clr = i_status.crc_hi_ok;
            end
            mrfr_pkg::S_EMIT_RD: o_cmd.rd_sel = mrfr_pkg::RD_IDX;
            mrfr_pkg::S_EMIT_LD: o_cmd.out_load = 1'b1;
            mrfr_pkg::S_EMIT_WAIT: begin
                o_cmd.clear_count = i_status.out_taken && i_status.out_last;
                o_cmd.idx_inc     = i_status.out_taken && !i_status.out_last;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ src/modbus_rtu_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver
// Modbus RTU slave receiver: buffers bytes, resyncs on header, checks CRC-16
// and outputs each validated frame one byte per request.
//
//   channel  | direction | handshake                  | payload
//   rx       | in        | i_rx_valid / o_rx_stall    | i_rx_byte
//   frame    | out       | o_frame_valid / i_frame_stall | o_frame_byte, o_byte_index, o_last_byte
//   cfg      | in        | i_cfg_wr_en                | i_cfg_wr_data (slave address)
//
// One byte request at a time; o_rx_stall is low only in the idle state.
// With 3 to 7 bytes held, a new byte is taken straight back in idle; with 1 or 2 held, the
// header is checked, dropping bytes on address or function mismatch until it passes or empties.
// From 8 held bytes the length is checked, with a CRC pass once the whole frame is held.
// Output of each frame byte waits while i_frame_stall is high.
// Reset (synchronous, i_rst_n low) empties the store; its contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_frame_receiver #(
    parameter int BUFFER_BYTES = mrfr_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_frame_valid,
    input  wire logic       i_frame_stall,
    output logic [7:0]      o_frame_byte,
    output logic [5:0]      o_byte_index,
    output logic            o_last_byte
);

    mrfr_pkg::t_cmd    cmd;
    mrfr_pkg::t_status status;

    mrfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_status   (status),
        .o_rx_stall (o_rx_stall),
        .o_cmd      (cmd)
    );

    mrfr_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_byte     (i_rx_byte),
        .i_frame_stall (i_frame_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_frame_valid (o_frame_valid),
        .o_frame_byte  (o_frame_byte),
        .o_byte_index  (o_byte_index),
        .o_last_byte   (o_last_byte)
    );

endmodule

`default_nettype wire
